@@ rtl/olir_pkg.sv @@
// shared types, codes and sizes for the ordered list insert/remove core
`timescale 1ns / 1ps

package olir_pkg;

    // list geometry
    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 32;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int ST_W     = 3;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // operation codes
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP      = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD_POS  = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FND  = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

    // input transaction
    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [POS_W-1:0]    position;
        logic [KEY_BITS-1:0] key;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic [ST_W-1:0]     status;
        logic [KEY_BITS-1:0] entry_key;
        logic [IDX_W-1:0]    entry_index;
        logic [CNT_W-1:0]    fill_count;
        logic                last;
    } t_out_item;

    // entry store access from the sequencer
    typedef struct packed {
        logic                we;
        logic [IDX_W-1:0]    waddr;
        logic [KEY_BITS-1:0] wdata;
        logic                re;
        logic [IDX_W-1:0]    raddr;
    } t_mem_ctl;

    // request to the shared step unit
    typedef struct packed {
        logic             dec;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] bound;
    } t_step_req;

    // answer of the shared step unit
    typedef struct packed {
        logic [CNT_W-1:0] idx_nxt;
        logic             at_bound;
        logic             key_eq;
    } t_step_rsp;

endpackage

@@ rtl/ordered_list_insert_remove_core.sv @@
// top level: entry store, output register and the list sequencer
//
// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+---------------------------
// in      | into core | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
// out     | from core | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// one transaction at a time; an entry store with registered read and one
// shared step unit visit the list one slot at a time.
// insert moves the entries at and above the insert slot up one, then writes
// the key; remove searches for the first matching key, then moves the later
// entries down; dump gives one result per entry, every other transaction or
// an empty dump a single status result. reset empties the list.
// a stalled output holds the sequencer; a new transaction is taken while the
// last result still waits in the output register.
`timescale 1ns / 1ps

module ordered_list_insert_remove_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  olir_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output olir_pkg::t_out_item   o_out_data
);

    logic [olir_pkg::KEY_BITS-1:0] r_mem [olir_pkg::DEPTH];
    logic [olir_pkg::KEY_BITS-1:0] r_rd_data;
    logic                          r_out_valid, n_out_valid;
    olir_pkg::t_out_item           r_out_data;

    olir_pkg::t_mem_ctl            mem_ctl;
    olir_pkg::t_out_item           res;
    logic                          emit;
    logic                          busy;
    logic                          slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    olir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in_data),
        .i_rd_data   (r_rd_data),
        .i_slot_free (slot_free),
        .o_busy      (busy),
        .o_mem       (mem_ctl),
        .o_emit      (emit),
        .o_res       (res)
    );

    // entry store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_ctl.we) begin
            r_mem[mem_ctl.waddr] <= mem_ctl.wdata;
        end
        if (mem_ctl.re) begin
            r_rd_data <= r_mem[mem_ctl.raddr];
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= res;
        end
    end

    // a result is only loaded when the output register is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> slot_free)
        else $error("result loaded over a waiting transaction");

    // the store is never written while a new transaction can be taken
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !mem_ctl.we)
        else $error("entry store written while idle");

    // fill count stays within the list depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.fill_count <= olir_pkg::CNT_FULL))
        else $error("fill count beyond depth");

    // a dump entry that is not the last lies below the fill count
    a_dump_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.last)
            |-> ((olir_pkg::CNT_W'(r_out_data.entry_index) + olir_pkg::CNT_ONE)
                 < r_out_data.fill_count))
        else $error("dump index past the end of the list");

endmodule

@@ rtl/olir_step.sv @@
// shared step unit: slot index increment/decrement, bound check and key compare
`timescale 1ns / 1ps

module olir_step (
    input  olir_pkg::t_step_req             i_req,
    input  logic [olir_pkg::KEY_BITS-1:0]   i_rd_data,
    input  logic [olir_pkg::KEY_BITS-1:0]   i_key,
    output olir_pkg::t_step_rsp             o_rsp
);

    logic [olir_pkg::CNT_W-1:0] idx_nxt;

    // one adder serves both walking directions
    assign idx_nxt = i_req.dec ? (i_req.idx - olir_pkg::CNT_ONE)
                               : (i_req.idx + olir_pkg::CNT_ONE);

    // end of walk and key match
    assign o_rsp.idx_nxt  = idx_nxt;
    assign o_rsp.at_bound = (idx_nxt == i_req.bound);
    assign o_rsp.key_eq   = (i_rd_data == i_key);

endmodule

@@ rtl/olir_ctrl.sv @@
// sequencer that walks the entry store one slot at a time for each operation
`timescale 1ns / 1ps

module olir_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  olir_pkg::t_in_item              i_in,
    input  logic [olir_pkg::KEY_BITS-1:0]   i_rd_data,
    input  logic                            i_slot_free,
    output logic                            o_busy,
    output olir_pkg::t_mem_ctl              o_mem,
    output logic                            o_emit,
    output olir_pkg::t_out_item             o_res
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SHIFT_RD = 11'b000_0000_0010,
        S_SHIFT_WR = 11'b000_0000_0100,
        S_PUT      = 11'b000_0000_1000,
        S_SRCH_RD  = 11'b000_0001_0000,
        S_SRCH_CMP = 11'b000_0010_0000,
        S_DEL_RD   = 11'b000_0100_0000,
        S_DEL_WR   = 11'b000_1000_0000,
        S_DUMP_RD  = 11'b001_0000_0000,
        S_DUMP_OUT = 11'b010_0000_0000,
        S_EMIT     = 11'b100_0000_0000
    } t_state;

    t_state                        r_state, n_state;
    logic [olir_pkg::CNT_W-1:0]    r_idx, n_idx;
    logic [olir_pkg::CNT_W-1:0]    r_pos, n_pos;
    logic [olir_pkg::CNT_W-1:0]    r_count, n_count;
    logic [olir_pkg::KEY_BITS-1:0] r_key, n_key;
    logic [olir_pkg::ST_W-1:0]     r_status, n_status;

    logic [olir_pkg::CNT_W-1:0]    slot;
    logic [olir_pkg::CNT_W-1:0]    in_pos;
    olir_pkg::t_step_req           step_req;
    olir_pkg::t_step_rsp           step_rsp;

    assign o_busy = (r_state != S_IDLE);

    // target slot of an insert
    assign in_pos = olir_pkg::CNT_W'(i_in.position);
    always_comb begin
        priority if (i_in.operation == olir_pkg::OP_INS_FRONT) begin
            slot = '0;
        end else if (i_in.operation == olir_pkg::OP_INS_END) begin
            slot = r_count;
        end else begin
            slot = in_pos;
        end
    end

    // step unit setup: shifting up walks down toward the insert slot,
    // search and dump stop at the count, delete stops one short of it
    always_comb begin
        step_req.dec   = (r_state == S_SHIFT_RD) || (r_state == S_SHIFT_WR);
        step_req.idx   = r_idx;
        step_req.bound = r_count;
        if (step_req.dec) begin
            step_req.bound = r_pos;
        end else if ((r_state == S_DEL_RD) || (r_state == S_DEL_WR)) begin
            step_req.bound = r_count - olir_pkg::CNT_ONE;
        end
    end

    olir_step u_step (
        .i_req     (step_req),
        .i_rd_data (i_rd_data),
        .i_key     (r_key),
        .o_rsp     (step_rsp)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_count  = r_count;
        n_key    = r_key;
        n_status = r_status;
        o_mem    = '0;
        o_emit   = 1'b0;
        o_res    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key    = i_in.key;
                    n_status = olir_pkg::ST_OK;
                    n_idx    = '0;
                    n_state  = S_EMIT;
                    priority if ((i_in.operation == olir_pkg::OP_INS_FRONT)
                                 || (i_in.operation == olir_pkg::OP_INS_END)
                                 || (i_in.operation == olir_pkg::OP_INS_POS)) begin
                        if (r_count == olir_pkg::CNT_FULL) begin
                            n_status = (i_in.operation == olir_pkg::OP_INS_POS)
                                     ? olir_pkg::ST_BAD_POS : olir_pkg::ST_FULL;
                        end else if ((i_in.operation == olir_pkg::OP_INS_POS)
                                     && (in_pos > r_count)) begin
                            n_status = olir_pkg::ST_BAD_POS;
                        end else begin
                            n_pos   = slot;
                            n_idx   = r_count;
                            n_state = (r_count == slot) ? S_PUT : S_SHIFT_RD;
                        end
                    end else if (i_in.operation == olir_pkg::OP_REMOVE) begin
                        if (r_count == '0) begin
                            n_status = olir_pkg::ST_NOT_FND;
                        end else begin
                            n_state = S_SRCH_RD;
                        end
                    end else if (i_in.operation == olir_pkg::OP_DUMP) begin
                        if (r_count == '0) begin
                            n_status = olir_pkg::ST_EMPTY;
                        end else begin
                            n_state = S_DUMP_RD;
                        end
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            // move the entry below r_idx up into r_idx
            S_SHIFT_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = step_rsp.idx_nxt[olir_pkg::IDX_W-1:0];
                n_state     = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx[olir_pkg::IDX_W-1:0];
                o_mem.wdata = i_rd_data;
                n_idx       = step_rsp.idx_nxt;
                n_state     = step_rsp.at_bound ? S_PUT : S_SHIFT_RD;
            end
            S_PUT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_pos[olir_pkg::IDX_W-1:0];
                o_mem.wdata = r_key;
                n_count     = r_count + olir_pkg::CNT_ONE;
                n_state     = S_EMIT;
            end
            // linear search for the first matching key
            S_SRCH_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_idx[olir_pkg::IDX_W-1:0];
                n_state     = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (step_rsp.key_eq) begin
                    if (step_rsp.at_bound) begin
                        n_count = r_count - olir_pkg::CNT_ONE;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_DEL_RD;
                    end
                end else begin
                    n_idx = step_rsp.idx_nxt;
                    if (step_rsp.at_bound) begin
                        n_status = olir_pkg::ST_NOT_FND;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_SRCH_RD;
                    end
                end
            end
            // close the gap: entry above r_idx moves down into r_idx
            S_DEL_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = step_rsp.idx_nxt[olir_pkg::IDX_W-1:0];
                n_state     = S_DEL_WR;
            end
            S_DEL_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx[olir_pkg::IDX_W-1:0];
                o_mem.wdata = i_rd_data;
                n_idx       = step_rsp.idx_nxt;
                if (step_rsp.at_bound) begin
                    n_count = r_count - olir_pkg::CNT_ONE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DEL_RD;
                end
            end
            // one result per entry
            S_DUMP_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_idx[olir_pkg::IDX_W-1:0];
                n_state     = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (i_slot_free) begin
                    o_emit            = 1'b1;
                    o_res.status      = olir_pkg::ST_OK;
                    o_res.entry_key   = i_rd_data;
                    o_res.entry_index = r_idx[olir_pkg::IDX_W-1:0];
                    o_res.fill_count  = r_count;
                    o_res.last        = step_rsp.at_bound;
                    n_idx             = step_rsp.idx_nxt;
                    n_state           = step_rsp.at_bound ? S_IDLE : S_DUMP_RD;
                end
            end
            // single status result
            S_EMIT: begin
                if (i_slot_free) begin
                    o_emit           = 1'b1;
                    o_res.status     = r_status;
                    o_res.fill_count = r_count;
                    o_res.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_status <= n_status;
    end

endmodule

@@ verif/tb.sv @@
// testbench for the ordered list core: list tracker predicts results, tasks drive the ports
`timescale 1ns / 1ps

module tb;
    import olir_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 10;
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 64;
    localparam int FIXED_ITEM   = -1;
    localparam int MAX_LINES    = 40;

    localparam logic [OP_W-1:0]     OP_SPARE_LO = OP_DUMP + 3'd1;
    localparam logic [KEY_BITS-1:0] KEY_ONES    = '1;

    // list tracker: own copy of the list, queue of results still due
    class list_tracker;
        logic [KEY_BITS-1:0] slot_key [DEPTH];
        int                  fill;
        t_out_item           due_q [$];
        int                  mismatches;
        int                  lines;

        function new();
            fill       = 0;
            mismatches = 0;
            lines      = 0;
        endfunction

        function t_out_item make_result(logic [ST_W-1:0] st, logic [KEY_BITS-1:0] k,
                                        int idx, bit fin);
            t_out_item r;
            r.status      = st;
            r.entry_key   = k;
            r.entry_index = IDX_W'(idx);
            r.fill_count  = CNT_W'(fill);
            r.last        = fin;
            return r;
        endfunction

        // later entries move up one slot
        function void insert_at(int slot, logic [KEY_BITS-1:0] k);
            for (int i = fill; i > slot; i--)
                slot_key[i] = slot_key[i-1];
            slot_key[slot] = k;
            fill++;
        endfunction

        // accepted input transaction: update list, queue its results
        function void note_request(t_in_item req);
            logic [ST_W-1:0] st;
            int              hit;
            st  = ST_OK;
            hit = -1;
            case (req.operation)
                OP_INS_FRONT: begin
                    if (fill >= DEPTH) st = ST_FULL;
                    else insert_at(0, req.key);
                end
                OP_INS_END: begin
                    if (fill >= DEPTH) st = ST_FULL;
                    else insert_at(fill, req.key);
                end
                OP_INS_POS: begin
                    if (int'(req.position) > fill || fill >= DEPTH) st = ST_BAD_POS;
                    else insert_at(int'(req.position), req.key);
                end
                OP_REMOVE: begin
                    for (int i = 0; i < fill; i++)
                        if (hit < 0 && slot_key[i] == req.key) hit = i;
                    if (hit < 0) begin
                        st = ST_NOT_FND;
                    end else begin
                        for (int j = hit; j + 1 < fill; j++)
                            slot_key[j] = slot_key[j+1];
                        fill--;
                    end
                end
                OP_DUMP: begin
                    if (fill == 0) begin
                        st = ST_EMPTY;
                    end else begin
                        for (int i = 0; i < fill; i++)
                            due_q.push_back(make_result(ST_OK, slot_key[i], i, i == fill - 1));
                        return;
                    end
                end
                default: ;
            endcase
            due_q.push_back(make_result(st, '0, 0, 1'b1));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (lines < MAX_LINES) begin
                $display("%0t error: %s", $time, msg);
                lines++;
            end
        endtask

        // accepted output transaction against the oldest expectation
        task check_result(t_out_item got);
            t_out_item want;
            if (due_q.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing due", got));
                return;
            end
            want = due_q.pop_front();
            if (got !== want)
                report_mismatch($sformatf(
                    "status %0d/%0d key %h/%h index %0d/%0d fill %0d/%0d last %b/%b (got/want)",
                    got.status, want.status, got.entry_key, want.entry_key,
                    got.entry_index, want.entry_index, got.fill_count, want.fill_count,
                    got.last, want.last));
        endtask
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_req = 1'b0;
    list_tracker tracker = new();

    ordered_list_insert_remove_core uut (.*);

    // clock
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // monitor both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) tracker.note_request(i_in_data);
        if (i_rst_n && o_out_valid && !i_out_stall) tracker.check_result(o_out_data);
    end

    // receiver: random stall, or a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("ordered_list_insert_remove_core: mismatch");
        $finish;
    end

    // random transaction, mostly edits that keep the list busy
    function t_in_item pick_item(int ins_bias);
        t_in_item it;
        int       roll;
        it.operation = OP_DUMP;
        it.position  = POS_W'($urandom);
        it.key       = $urandom;
        roll = $urandom_range(99);
        if (roll < 4) begin
            it.operation = OP_SPARE_LO + OP_W'($urandom_range(2));
        end else if (roll < 14) begin
            it.operation = OP_DUMP;
        end else if ($urandom_range(99) < ins_bias) begin
            case ($urandom_range(2))
                0:       it.operation = OP_INS_FRONT;
                1:       it.operation = OP_INS_END;
                default: it.operation = OP_INS_POS;
            endcase
            if ($urandom_range(9) < 8) it.position = POS_W'($urandom_range(tracker.fill));
            roll = $urandom_range(9);
            // duplicates and extreme keys now and then
            if (roll < 2 && tracker.fill > 0)
                it.key = tracker.slot_key[$urandom_range(tracker.fill - 1)];
            else if (roll == 2)
                it.key = '0;
            else if (roll == 3)
                it.key = KEY_ONES;
        end else begin
            it.operation = OP_REMOVE;
            if ($urandom_range(9) < 8 && tracker.fill > 0)
                it.key = tracker.slot_key[$urandom_range(tracker.fill - 1)];
        end
        return it;
    endfunction

    // offer one transaction after random idle, hold it until accepted
    task send_item(t_in_item fixed, int ins_bias);
        t_in_item it;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        it = (ins_bias == FIXED_ITEM) ? fixed : pick_item(ins_bias);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        // withdraw once taken so the same transaction is not offered again
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task send_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [KEY_BITS-1:0] key);
        t_in_item d;
        d.operation = op;
        d.position  = pos;
        d.key       = key;
        send_item(d, FIXED_ITEM);
    endtask

    // alternate fill-heavy and drain-heavy stretches
    task run_random(int count);
        for (int k = 0; k < count; k++)
            send_item('0, ((k / 40) % 2 == 0) ? 70 : 30);
    endtask

    task wait_drained();
        while (tracker.due_q.size() != 0) @(posedge i_clk);
    endtask

    // main sequence
    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty list corner cases
        send_op(OP_DUMP, '0, '0);
        send_op(OP_REMOVE, '0, KEY_ONES);
        send_op(OP_INS_POS, 5'd1, 32'h0000_0001);
        send_op(OP_INS_POS, '0, '0);
        send_op(OP_INS_FRONT, 5'd31, KEY_ONES);
        send_op(OP_INS_END, '0, 32'h1234_5678);
        // insert at position equal to the count, then past it
        send_op(OP_INS_POS, 5'd3, 32'hA5A5_A5A5);
        send_op(OP_INS_POS, 5'd31, KEY_ONES);
        // duplicate key: remove takes the first one
        send_op(OP_INS_FRONT, '0, 32'h1234_5678);
        send_op(OP_REMOVE, '0, 32'h1234_5678);
        send_op(OP_REMOVE, '0, 32'h5A5A_5A5A);
        send_op(OP_DUMP, '0, '0);
        // unused operation codes
        for (int k = 0; k < 3; k++)
            send_op(OP_SPARE_LO + OP_W'(k), POS_W'($urandom), $urandom);
        // fill up from four entries
        for (int k = 0; k < DEPTH - 4; k++) begin
            case (k % 3)
                0:       send_op(OP_INS_FRONT, '0, $urandom);
                1:       send_op(OP_INS_END, '0, $urandom);
                default: send_op(OP_INS_POS, POS_W'($urandom_range(4 + k)), $urandom);
            endcase
        end
        // full list
        send_op(OP_INS_FRONT, '0, $urandom);
        send_op(OP_INS_END, '0, $urandom);
        send_op(OP_INS_POS, '0, $urandom);
        send_op(OP_INS_POS, 5'd16, $urandom);
        send_op(OP_DUMP, '0, '0);
        send_op(OP_REMOVE, '0, KEY_ONES);
        wait_drained();

        // no idling
        run_random(70);
        wait_drained();

        // receiver holds off while the sender keeps offering
        hold_req = 1'b1;
        run_random(20);
        wait_drained();

        // sender mostly idle
        idle_pct  = 80;
        stall_pct = 0;
        run_random(100);

        // receiver mostly stalling
        idle_pct  = 0;
        stall_pct = 80;
        run_random(100);

        // both sides idling
        idle_pct  = 28;
        stall_pct = 28;
        run_random(100);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.due_q.size() == 0)
            $display("ordered_list_insert_remove_core: match");
        else
            $display("ordered_list_insert_remove_core: mismatch");
        $finish;
    end

endmodule
